FILE: design/topt_pkg.sv
`timescale 1ns / 1ps
// Shared types, byte codes and constants for the telnet option receive parser.
// Used by the front end, the queue, the emitter and the top level.
package topt_pkg;

  localparam int TRACKED_OPTIONS_DEFAULT = 4;
  localparam int QUEUE_DEPTH_DEFAULT     = 4;

  localparam logic [7:0] B_IAC     = 8'd255;
  localparam logic [7:0] B_DONT    = 8'd254;
  localparam logic [7:0] B_DO      = 8'd253;
  localparam logic [7:0] B_WONT    = 8'd252;
  localparam logic [7:0] B_WILL    = 8'd251;
  localparam logic [7:0] B_SB      = 8'd250;
  localparam logic [7:0] B_SE      = 8'd240;
  localparam logic [7:0] OPT_WINCH = 8'd31;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_NUL    = 8'd0;

  localparam logic [1:0] SIZE_LAST_POS = 2'd3;

  localparam logic [1:0] KIND_TERM = 2'd0;
  localparam logic [1:0] KIND_NET  = 2'd1;
  localparam logic [1:0] KIND_SIZE = 2'd2;

  localparam logic [1:0] CMD_WILL = 2'd0;
  localparam logic [1:0] CMD_WONT = 2'd1;
  localparam logic [1:0] CMD_DO   = 2'd2;
  localparam logic [1:0] CMD_DONT = 2'd3;

  localparam logic [1:0] REQ_DO   = 2'd0;
  localparam logic [1:0] REQ_DONT = 2'd1;
  localparam logic [1:0] REQ_WILL = 2'd2;
  localparam logic [1:0] REQ_WONT = 2'd3;

  localparam logic       MODE_RX  = 1'b0;
  localparam logic       MODE_REQ = 1'b1;

  typedef enum logic [2:0] {
    ST_DATA = 3'd0,
    ST_CR   = 3'd1,
    ST_IAC  = 3'd2,
    ST_OPT  = 3'd3,
    ST_SB   = 3'd4
  } parse_state_t;

  typedef enum logic [1:0] {
    JOB_DATA = 2'd0,
    JOB_NET3 = 2'd1,
    JOB_SIZE = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [31:0] payload;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [7:0] req_code(input logic [1:0] cmd);
    logic [7:0] code;
    unique case (cmd)
      REQ_DO:   code = B_DO;
      REQ_DONT: code = B_DONT;
      REQ_WILL: code = B_WILL;
      default:  code = B_WONT;
    endcase
    return code;
  endfunction

endpackage

FILE: design/topt_in_if.sv
`timescale 1ns / 1ps
// Input channel: one received byte or one local option request per item.
// Depends on nothing.
interface topt_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;
  logic [1:0] req_command;
  logic [7:0] req_option;

  modport source (output valid, mode, rx_byte, req_command, req_option, input ready);
  modport sink   (input valid, mode, rx_byte, req_command, req_option, output ready);
endinterface

FILE: design/topt_out_if.sv
`timescale 1ns / 1ps
// Output channel: one terminal byte, network byte or window size per item.
// Depends on nothing.
interface topt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [15:0] cols;
  logic [15:0] rows;
  logic        last;

  modport source (output valid, kind, out_byte, cols, rows, last, input ready);
  modport sink   (input valid, kind, out_byte, cols, rows, last, output ready);
endinterface

FILE: design/topt_queue.sv
`timescale 1ns / 1ps
// Short job queue between the front end and the emitter.
// Depends on topt_pkg.
module topt_queue
  import topt_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  job_t          push_job,
  input  logic          pop,
  output job_t          head_job,
  output queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == CNT_FULL);
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_job     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/topt_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, runs the telnet receive state machine and option
// flags, and queues one job per item that produces results. Depends on topt_pkg and topt_in_if.
module topt_front
  import topt_pkg::*;
#(
  parameter int TRACKED_OPTIONS = TRACKED_OPTIONS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  topt_in_if.sink       in_ch,
  input  queue_status_t q_status,
  output logic          push,
  output job_t          push_job
);

  localparam int IDX_W = $clog2(TRACKED_OPTIONS);
  localparam logic [7:0] NUM_TRACKED = 8'(TRACKED_OPTIONS);

  parse_state_t               parse_state, parse_state_next;
  logic [1:0]                 pending_command, pending_command_next;
  logic [TRACKED_OPTIONS-1:0] remote_flags, remote_flags_next;
  logic [TRACKED_OPTIONS-1:0] local_flags, local_flags_next;
  logic                       winch_agreed, winch_agreed_next;
  logic                       collecting, collecting_next;
  logic [1:0]                 size_pos, size_pos_next;
  logic                       iac_run, iac_run_next;
  logic                       sub_last_iac, sub_last_iac_next;
  logic [7:0]                 size_bytes [3];

  logic             accept;
  logic [7:0]       c;
  logic [7:0]       opt;
  logic [1:0]       cmd;
  logic             c_tracked;
  logic             opt_tracked;
  logic [IDX_W-1:0] c_idx;
  logic [IDX_W-1:0] opt_idx;
  logic             data_path;
  logic             size_advance;
  logic             size_done;
  logic             will_remote;
  logic             will_winch;
  logic             req_send;
  logic             size_we;
  logic             job_valid;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign c           = in_ch.rx_byte;
  assign opt         = in_ch.req_option;
  assign cmd         = in_ch.req_command;
  assign c_tracked   = (c < NUM_TRACKED);
  assign opt_tracked = (opt < NUM_TRACKED);
  assign c_idx       = c[IDX_W-1:0];
  assign opt_idx     = opt[IDX_W-1:0];

  assign data_path    = (parse_state == ST_DATA) ||
                        ((parse_state == ST_CR) && (c != CH_NUL) && (c != CH_LF));
  assign size_advance = (c != B_IAC) || iac_run;
  assign size_done    = collecting && size_advance && (size_pos == SIZE_LAST_POS);
  assign will_remote  = (c == 8'd0) || (c == 8'd1) || (c == 8'd3);
  assign will_winch   = (pending_command == CMD_WILL) && !will_remote &&
                        (c == OPT_WINCH) && !winch_agreed;
  assign size_we      = accept && (in_ch.mode == MODE_RX) && (parse_state == ST_SB) &&
                        collecting && (size_pos != SIZE_LAST_POS);

  always_comb begin
    unique case (cmd)
      REQ_DO:  req_send = opt_tracked || ((opt == OPT_WINCH) && !winch_agreed);
      default: req_send = opt_tracked;
    endcase
  end

  always_comb begin
    parse_state_next     = parse_state;
    pending_command_next = pending_command;
    remote_flags_next    = remote_flags;
    local_flags_next     = local_flags;
    winch_agreed_next    = winch_agreed;
    collecting_next      = collecting;
    size_pos_next        = size_pos;
    iac_run_next         = iac_run;
    sub_last_iac_next    = sub_last_iac;
    if (in_ch.mode == MODE_REQ) begin
      unique case (cmd)
        REQ_DO: begin
          if (opt_tracked) begin
            remote_flags_next[opt_idx] = 1'b1;
          end else if ((opt == OPT_WINCH) && !winch_agreed) begin
            winch_agreed_next = 1'b1;
          end
        end
        REQ_DONT: begin
          if (opt_tracked) begin
            remote_flags_next[opt_idx] = 1'b1;
          end
        end
        default: begin
          if (opt_tracked) begin
            local_flags_next[opt_idx] = 1'b1;
          end
        end
      endcase
    end else begin
      unique case (parse_state)
        ST_DATA, ST_CR: begin
          parse_state_next = ST_DATA;
          if (data_path) begin
            if (c == B_IAC) begin
              parse_state_next = ST_IAC;
            end else if (c == CH_CR) begin
              parse_state_next = ST_CR;
            end
          end
        end
        ST_IAC: begin
          if ((c >= B_WILL) && (c <= B_DONT)) begin
            pending_command_next = 2'(c - B_WILL);
            parse_state_next     = ST_OPT;
          end else if (c == B_SB) begin
            parse_state_next = ST_SB;
          end else begin
            parse_state_next = ST_DATA;
          end
        end
        ST_OPT: begin
          parse_state_next = ST_DATA;
          unique case (pending_command)
            CMD_WILL: begin
              if (will_remote) begin
                remote_flags_next[c_idx] = 1'b1;
              end else if (will_winch) begin
                winch_agreed_next = 1'b1;
              end
            end
            CMD_WONT: begin
              if (c_tracked) begin
                remote_flags_next[c_idx] = 1'b0;
              end
            end
            CMD_DO: begin
            end
            default: begin
              if (c_tracked) begin
                local_flags_next[c_idx] = 1'b0;
              end
            end
          endcase
        end
        ST_SB: begin
          if (collecting) begin
            if (size_advance) begin
              iac_run_next = 1'b0;
              if (size_pos == SIZE_LAST_POS) begin
                collecting_next = 1'b0;
              end else begin
                size_pos_next = size_pos + 1'b1;
              end
            end else begin
              iac_run_next = 1'b1;
            end
          end else begin
            if (c == OPT_WINCH) begin
              collecting_next = 1'b1;
              size_pos_next   = '0;
              iac_run_next    = 1'b0;
            end else if ((c == B_SE) && sub_last_iac) begin
              parse_state_next = ST_DATA;
            end
            sub_last_iac_next = (c == B_IAC);
          end
        end
        default: begin
          parse_state_next = ST_DATA;
        end
      endcase
    end
  end

  always_comb begin
    job_valid        = 1'b0;
    push_job.kind    = JOB_DATA;
    push_job.payload = {24'd0, c};
    if (in_ch.mode == MODE_REQ) begin
      job_valid        = req_send;
      push_job.kind    = JOB_NET3;
      push_job.payload = {16'd0, req_code(cmd), opt};
    end else begin
      unique case (parse_state)
        ST_DATA, ST_CR: begin
          job_valid = data_path && (c != B_IAC);
        end
        ST_IAC: begin
          job_valid = (c == B_IAC);
        end
        ST_OPT: begin
          job_valid        = will_winch;
          push_job.kind    = JOB_NET3;
          push_job.payload = {16'd0, B_DO, OPT_WINCH};
        end
        ST_SB: begin
          job_valid        = size_done;
          push_job.kind    = JOB_SIZE;
          push_job.payload = {size_bytes[0], size_bytes[1], size_bytes[2], c};
        end
        default: begin
          job_valid = 1'b0;
        end
      endcase
    end
  end

  assign push = accept && job_valid;

  always_ff @(posedge clk) begin
    if (size_we) begin
      size_bytes[size_pos] <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state     <= ST_DATA;
      pending_command <= CMD_WILL;
      remote_flags    <= '0;
      local_flags     <= '0;
      winch_agreed    <= 1'b0;
      collecting      <= 1'b0;
      size_pos        <= '0;
      iac_run         <= 1'b0;
      sub_last_iac    <= 1'b0;
    end else if (accept) begin
      parse_state     <= parse_state_next;
      pending_command <= pending_command_next;
      remote_flags    <= remote_flags_next;
      local_flags     <= local_flags_next;
      winch_agreed    <= winch_agreed_next;
      collecting      <= collecting_next;
      size_pos        <= size_pos_next;
      iac_run         <= iac_run_next;
      sub_last_iac    <= sub_last_iac_next;
    end
  end

endmodule

FILE: design/topt_emit.sv
`timescale 1ns / 1ps
// Back end: takes jobs from the queue and emits one or three result items
// through an output register. Depends on topt_pkg and topt_out_if.
module topt_emit
  import topt_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  job_t          head_job,
  input  queue_status_t q_status,
  output logic          pop,
  topt_out_if.source    out_ch
);

  logic [1:0]  beat;
  logic        load;
  logic        final_beat;
  logic        out_valid;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [15:0] cols;
  logic [15:0] rows;
  logic        last;

  assign load       = !q_status.empty && (!out_valid || out_ch.ready);
  assign final_beat = (head_job.kind != JOB_NET3) || (beat == 2'd2);
  assign pop        = load && final_beat;

  assign out_ch.valid    = out_valid;
  assign out_ch.kind     = kind;
  assign out_ch.out_byte = out_byte;
  assign out_ch.cols     = cols;
  assign out_ch.rows     = rows;
  assign out_ch.last     = last;

  always_ff @(posedge clk) begin
    if (load) begin
      last <= final_beat;
      unique case (head_job.kind)
        JOB_NET3: begin
          kind <= KIND_NET;
          cols <= '0;
          rows <= '0;
          unique case (beat)
            2'd0:    out_byte <= B_IAC;
            2'd1:    out_byte <= head_job.payload[15:8];
            default: out_byte <= head_job.payload[7:0];
          endcase
        end
        JOB_SIZE: begin
          kind     <= KIND_SIZE;
          out_byte <= '0;
          cols     <= head_job.payload[31:16];
          rows     <= head_job.payload[15:0];
        end
        default: begin
          kind     <= KIND_TERM;
          out_byte <= head_job.payload[7:0];
          cols     <= '0;
          rows     <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        beat      <= final_beat ? 2'd0 : beat + 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/telnet_option_receive_parser.sv
`timescale 1ns / 1ps
// Telnet option receive parser: one input item per cycle while the job queue is not full.
// A data byte or window report is one result item; a negotiation reply is three,
// emitted in order through the output register while the job queue absorbs following input.
// Input is held off only when the job queue is full; output stalls back up into it.
// Synchronous reset returns to the data state with all flags and the queue cleared.
module telnet_option_receive_parser
  import topt_pkg::*;
#(
  parameter int TRACKED_OPTIONS = TRACKED_OPTIONS_DEFAULT,
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  topt_in_if.sink    in_ch,
  topt_out_if.source out_ch
);

  queue_status_t q_status;
  logic          push;
  job_t          push_job;
  logic          pop;
  job_t          head_job;

  topt_front #(
    .TRACKED_OPTIONS(TRACKED_OPTIONS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_status(q_status),
    .push    (push),
    .push_job(push_job)
  );

  topt_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head_job(head_job),
    .status  (q_status)
  );

  topt_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .head_job(head_job),
    .q_status(q_status),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
